@@ rtl/core/lfpd_pkg.sv @@
package lfpd_pkg;

  localparam logic [7:0] SOP_BYTE  = 8'hFE;
  localparam logic [7:0] EOP_BYTE  = 8'h0A;
  localparam int         HDR_BYTES = 8;
  localparam int         HDR_IDX_W = $clog2(HDR_BYTES);

  // parse phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_HDR     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  // result kind
  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   data_byte;
    logic [7:0]   msg_type;
    logic [7:0]   sub_type;
    logic [7:0]   device_id;
    logic [7:0]   endpoint_id;
    logic [31:0]  reserved_word;
    logic [15:0]  payload_length;
  } result_t;

endpackage

@@ rtl/core/length_framed_packet_deframer.sv @@
// path: a byte beat is held in the input register, parsed, and its result beat (if any)
// is loaded into the result register; throughput: one byte beat per cycle while out_tready
// holds, set by the single-pass parser between the input register and the result register
// reset: rst_n synchronous active low; clears the parse phase, counters and valids,
// the block then hunts for a start byte; header bytes are not cleared
module length_framed_packet_deframer (
  input  logic         clk,
  input  logic         rst_n,
  // byte stream in
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  // result stream out
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,  // [7:0] data_byte, [15:8] msg_type, [23:16] sub_type,
                                   // [31:24] device_id, [39:32] endpoint_id,
                                   // [71:40] reserved_word, [87:72] payload_length
  output logic [1:0]   out_tuser   // [1:0] kind
);

  // input register
  logic                in_vld_r;
  logic [7:0]          in_byte_r;

  // result register
  logic                out_vld_r;
  lfpd_pkg::result_t   out_res_r;

  // parser result for the byte in the input register
  logic                res_vld;
  lfpd_pkg::result_t   res;

  logic                out_free;
  logic                proc_fire;

  // result register can load when empty or being drained this cycle
  assign out_free  = !out_vld_r || out_tready;
  // the held byte is parsed as soon as its result (if any) has a place to go
  assign proc_fire = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (proc_fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  lfpd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_vld(proc_fire),
    .rx_byte (in_byte_r),
    .res_vld (res_vld),
    .res     (res)
  );

  // bytes outside a frame and header bytes give no beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= proc_fire && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {out_res_r.payload_length, out_res_r.reserved_word,
                       out_res_r.endpoint_id, out_res_r.device_id,
                       out_res_r.sub_type, out_res_r.msg_type,
                       out_res_r.data_byte};

endmodule

@@ rtl/core/lfpd_parser.sv @@
module lfpd_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_vld,
  input  logic [7:0]           rx_byte,
  output logic                 res_vld,
  output lfpd_pkg::result_t    res
);

  lfpd_pkg::phase_t                    phase_r, phase_nxt;
  logic [15:0]                         frame_length_r, frame_length_nxt;
  logic [15:0]                         bytes_left_r, bytes_left_nxt;
  logic [lfpd_pkg::HDR_IDX_W-1:0]      header_count_r, header_count_nxt;
  logic [7:0]                          header_store_r [lfpd_pkg::HDR_BYTES];
  logic                                hdr_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= lfpd_pkg::PH_HUNT;
      frame_length_r <= '0;
      bytes_left_r   <= '0;
      header_count_r <= '0;
    end else if (byte_vld) begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_left_r   <= bytes_left_nxt;
      header_count_r <= header_count_nxt;
    end
  end

  // header bytes, only read after the whole header was written
  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      header_store_r[header_count_r] <= rx_byte;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    bytes_left_nxt   = bytes_left_r;
    header_count_nxt = header_count_r;
    hdr_wr           = 1'b0;
    res_vld          = 1'b0;
    res.kind           = lfpd_pkg::KIND_DATA;
    res.data_byte      = 8'h00;
    res.msg_type       = header_store_r[0];
    res.sub_type       = header_store_r[1];
    res.device_id      = header_store_r[2];
    res.endpoint_id    = header_store_r[3];
    res.reserved_word  = {header_store_r[7], header_store_r[6],
                          header_store_r[5], header_store_r[4]};
    res.payload_length = frame_length_r;
    case (phase_r)
      lfpd_pkg::PH_HUNT: begin
        if (rx_byte == lfpd_pkg::SOP_BYTE) begin
          phase_nxt = lfpd_pkg::PH_LEN_LO;
        end
      end
      lfpd_pkg::PH_LEN_LO: begin
        frame_length_nxt = {8'h00, rx_byte};
        phase_nxt        = lfpd_pkg::PH_LEN_HI;
      end
      lfpd_pkg::PH_LEN_HI: begin
        frame_length_nxt = {rx_byte, frame_length_r[7:0]};
        header_count_nxt = '0;
        phase_nxt        = lfpd_pkg::PH_HDR;
      end
      lfpd_pkg::PH_HDR: begin
        hdr_wr           = byte_vld;
        header_count_nxt = header_count_r + 1'b1;
        if (header_count_r == lfpd_pkg::HDR_IDX_W'(lfpd_pkg::HDR_BYTES - 1)) begin
          if (frame_length_r != 16'h0000) begin
            bytes_left_nxt = frame_length_r;
            phase_nxt      = lfpd_pkg::PH_PAYLOAD;
          end else begin
            phase_nxt = lfpd_pkg::PH_END;
          end
        end
      end
      lfpd_pkg::PH_PAYLOAD: begin
        res_vld        = 1'b1;
        res.data_byte  = rx_byte;
        bytes_left_nxt = bytes_left_r - 16'd1;
        if (bytes_left_r == 16'd1) begin
          phase_nxt = lfpd_pkg::PH_END;
        end
      end
      lfpd_pkg::PH_END: begin
        res_vld   = 1'b1;
        res.kind  = (rx_byte == lfpd_pkg::EOP_BYTE) ? lfpd_pkg::KIND_DONE
                                                    : lfpd_pkg::KIND_REJECT;
        phase_nxt = lfpd_pkg::PH_HUNT;
      end
      default: begin
        phase_nxt = lfpd_pkg::PH_HUNT;
      end
    endcase
  end

endmodule

@@ rtl/core/lfpd_checker.sv @@
module lfpd_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [87:0]  out_tdata,
  input  logic [1:0]   out_tuser
);

  logic in_beat;
  assign in_beat = in_tvalid && in_tready;

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat dropped or changed while stalled");

  // no result beat right after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  // kind is never the unused code
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == lfpd_pkg::KIND_DATA || out_tuser == lfpd_pkg::KIND_DONE ||
                   out_tuser == lfpd_pkg::KIND_REJECT)
    else $error("unused kind code");

  // end-of-frame beats carry a zero data byte
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != lfpd_pkg::KIND_DATA |-> out_tdata[7:0] == 8'h00)
    else $error("end beat with nonzero data byte");

  // a fresh result beat comes from a byte taken earlier through the input register
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_beat, 2))
    else $error("result beat without any input byte");

endmodule

bind length_framed_packet_deframer lfpd_checker u_lfpd_checker (.*);
